### rtl/core/glpd_pkg.sv
// Shared types, constants and helpers of the LZW pixel decoder core.
// No dependencies; every other file of the block but glpd_ram imports it.
package glpd_pkg;

  localparam int unsigned STACK_DEPTH = 4096;
  localparam int unsigned STACK_AW    = 12;
  localparam int unsigned SC_W        = 13;
  localparam int unsigned CODE_W      = 12;
  localparam int unsigned BB_W        = 24;
  localparam int unsigned BC_W        = 5;
  localparam int unsigned CW_W        = 4;

  // decode phase codes
  localparam logic [1:0] PH_AWAIT_CLEAR = 2'd0;
  localparam logic [1:0] PH_AWAIT_FIRST = 2'd1;
  localparam logic [1:0] PH_RUN         = 2'd2;
  localparam logic [1:0] PH_DONE        = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_FIRST   = 2'd1;
  localparam logic [1:0] ERR_RANGE   = 2'd2;
  localparam logic [1:0] ERR_PENDING = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MIN_CODE = 3'd0;
  localparam logic [2:0] REG_LEFT     = 3'd1;
  localparam logic [2:0] REG_TOP      = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_SCREEN   = 3'd4;
  localparam logic [2:0] REG_TRANSP   = 3'd5;

  typedef struct packed {
    logic [3:0]  lzw_size;
    logic [15:0] image_left;
    logic [15:0] image_top;
    logic [15:0] image_width;
    logic [15:0] screen_width;
    logic [8:0]  transparent_index;
    logic        mcs_we;
    logic [3:0]  mcs_wdata;
  } cfg_t;

  typedef struct packed {
    logic        has_pixel;
    logic [7:0]  color_index;
    logic [31:0] pixel_offset;
    logic        is_transparent;
    logic [1:0]  error_code;
  } res_t;

  // minimum code size clamped to 2..8
  function automatic logic [3:0] eff_min(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (m < 4'd2) r = 4'd2;
    else if (m > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

### rtl/core/gif_lzw_pixel_decoder_core.sv
// LZW pixel decoder core: configuration registers, decode sequencer, result buffer.
// Depends on glpd_pkg, glpd_decoder, glpd_outbuf.

// One input item is one compressed byte (kind 0) or a resume request (kind 1).
// The item's results (up to PIXELS_PER_ITEM pixels and errors in all, or one
// status result) are collected in a buffer and then sent out, so more_pending and
// frame_done are the same in all of them. Pixels, codes, dictionary chain links
// and new entries are handled one at a time, as the chain walk through the
// prefix/suffix memories and the expand stack's single read port demand; then
// the results go out, held while the output stalls. The next item is taken
// once the last result has left.
// The dictionary and stack memories need no clearing after reset.
module gif_lzw_pixel_decoder_core import glpd_pkg::*; #(
  parameter int unsigned MAX_CODE_BITS   = 12,
  parameter int unsigned PIXELS_PER_ITEM = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        has_pixel_o,
  output logic [7:0]  color_index_o,
  output logic [31:0] pixel_offset_o,
  output logic        is_transparent_o,
  output logic        more_pending_o,
  output logic        frame_done_o,
  output logic [1:0]  error_code_o,
  output logic        last_o
);

  localparam int unsigned NW = $clog2(PIXELS_PER_ITEM + 1);
  localparam int unsigned PW = (PIXELS_PER_ITEM > 1) ? $clog2(PIXELS_PER_ITEM) : 1;

  logic [3:0]  mcs_q;
  logic [15:0] left_q, top_q, width_q, screen_q;
  logic [8:0]  transp_q;
  logic        wr;
  cfg_t        cfg;
  logic        in_ready, ob_busy, res_we, start, pend, done;
  logic [PW-1:0] res_wa;
  res_t        res_wd, out_res;
  logic [NW-1:0] count;

  // register writes
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcs_q    <= 4'd8;
      left_q   <= 16'd0;
      top_q    <= 16'd0;
      width_q  <= 16'd1;
      screen_q <= 16'd1;
      transp_q <= 9'd256;
    end else if (wr) begin
      case (paddr[4:2])
        REG_MIN_CODE: mcs_q    <= pwdata[3:0];
        REG_LEFT:     left_q   <= pwdata[15:0];
        REG_TOP:      top_q    <= pwdata[15:0];
        REG_WIDTH:    width_q  <= pwdata[15:0];
        REG_SCREEN:   screen_q <= pwdata[15:0];
        REG_TRANSP:   transp_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[4:2])
      REG_MIN_CODE: prdata = 32'(mcs_q);
      REG_LEFT:     prdata = 32'(left_q);
      REG_TOP:      prdata = 32'(top_q);
      REG_WIDTH:    prdata = 32'(width_q);
      REG_SCREEN:   prdata = 32'(screen_q);
      REG_TRANSP:   prdata = 32'(transp_q);
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg = '{lzw_size: mcs_q, image_left: left_q, image_top: top_q,
                 image_width: width_q, screen_width: screen_q,
                 transparent_index: transp_q,
                 mcs_we: wr && (paddr[4:2] == REG_MIN_CODE),
                 mcs_wdata: pwdata[3:0]};

  glpd_decoder #(
    .MAX_CODE_BITS(MAX_CODE_BITS), .PIXELS_PER_ITEM(PIXELS_PER_ITEM), .NW(NW), .PW(PW)
  ) u_dec (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready),
    .kind_i(kind_i), .data_byte_i(data_byte_i), .ob_busy_i(ob_busy),
    .res_we_o(res_we), .res_wa_o(res_wa), .res_wd_o(res_wd),
    .start_o(start), .count_o(count), .pend_o(pend), .done_o(done)
  );

  glpd_outbuf #(.PIXELS_PER_ITEM(PIXELS_PER_ITEM), .NW(NW), .PW(PW)) u_ob (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .wr_en_i(res_we), .wr_addr_i(res_wa), .wr_data_i(res_wd),
    .start_i(start), .count_i(count), .pend_i(pend), .done_i(done),
    .busy_o(ob_busy), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_res_o(out_res), .out_pend_o(more_pending_o), .out_done_o(frame_done_o),
    .out_last_o(last_o)
  );

  assign in_stall_o       = !in_ready;
  assign has_pixel_o      = out_res.has_pixel;
  assign color_index_o    = out_res.color_index;
  assign pixel_offset_o   = out_res.pixel_offset;
  assign is_transparent_o = out_res.is_transparent;
  assign error_code_o     = out_res.error_code;

endmodule

### rtl/core/glpd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module glpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/glpd_outbuf.sv
// Result buffer: holds the results of one item and replays them on the output.
// Depends on glpd_pkg and glpd_ram.
module glpd_outbuf import glpd_pkg::*; #(
  parameter int unsigned PIXELS_PER_ITEM = 64,
  parameter int unsigned NW = $clog2(PIXELS_PER_ITEM + 1),
  parameter int unsigned PW = (PIXELS_PER_ITEM > 1) ? $clog2(PIXELS_PER_ITEM) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [PW-1:0] wr_addr_i,
  input  res_t          wr_data_i,
  input  logic          start_i,
  input  logic [NW-1:0] count_i,
  input  logic          pend_i,
  input  logic          done_i,
  output logic          busy_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output res_t          out_res_o,
  output logic          out_pend_o,
  output logic          out_done_o,
  output logic          out_last_o
);

  logic          valid_q, valid_d;
  logic          stat_q, stat_d;
  logic          pend_q, pend_d, done_q, done_d;
  logic [NW-1:0] cnt_q, cnt_d, nxt_q, nxt_d;
  logic          re;
  logic [PW-1:0] ra;
  res_t          rdata;

  glpd_ram #(.WIDTH($bits(res_t)), .DEPTH(PIXELS_PER_ITEM), .AW(PW)) u_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .re_i    (re),
    .raddr_i (ra),
    .rdata_o (rdata)
  );

  // replay sequencer
  always_comb begin
    valid_d = valid_q;
    stat_d  = stat_q;
    pend_d  = pend_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    nxt_d   = nxt_q;
    re      = 1'b0;
    ra      = nxt_q[PW-1:0];
    if (start_i) begin
      valid_d = 1'b1;
      cnt_d   = count_i;
      pend_d  = pend_i;
      done_d  = done_i;
      stat_d  = (count_i == '0);
      re      = (count_i != '0);
      ra      = '0;
      nxt_d   = NW'(1);
    end else if (valid_q && !out_stall_i) begin
      if (stat_q || nxt_q == cnt_q) begin
        valid_d = 1'b0;
      end else begin
        re    = 1'b1;
        nxt_d = nxt_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      stat_q  <= 1'b0;
      cnt_q   <= '0;
      nxt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      stat_q  <= stat_d;
      cnt_q   <= cnt_d;
      nxt_q   <= nxt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    done_q <= done_d;
  end

  assign busy_o      = valid_q;
  assign out_valid_o = valid_q;
  assign out_res_o   = stat_q ? '0 : rdata;
  assign out_pend_o  = pend_q;
  assign out_done_o  = done_q;
  assign out_last_o  = stat_q || (nxt_q == cnt_q);

endmodule

### rtl/core/glpd_decoder.sv
// LZW decode sequencer: bit gathering, dictionary walk, expand stack, pixel emit.
// Depends on glpd_pkg and glpd_ram (dictionary and stack memories).
module glpd_decoder import glpd_pkg::*; #(
  parameter int unsigned MAX_CODE_BITS   = 12,
  parameter int unsigned PIXELS_PER_ITEM = 64,
  parameter int unsigned NW = $clog2(PIXELS_PER_ITEM + 1),
  parameter int unsigned PW = (PIXELS_PER_ITEM > 1) ? $clog2(PIXELS_PER_ITEM) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          kind_i,
  input  logic [7:0]    data_byte_i,
  input  logic          ob_busy_i,
  output logic          res_we_o,
  output logic [PW-1:0] res_wa_o,
  output res_t          res_wd_o,
  output logic          start_o,
  output logic [NW-1:0] count_o,
  output logic          pend_o,
  output logic          done_o
);

  localparam int unsigned MB = MAX_CODE_BITS;
  localparam int unsigned LIMIT = 1 << MAX_CODE_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EMIT   = 3'd1;
  localparam logic [2:0] S_CODE   = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_KWFIX  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]          st_q, st_d;
  logic [SC_W-1:0]     sc_q, sc_d;
  logic [BB_W-1:0]     bb_q, bb_d;
  logic [BC_W-1:0]     bc_q, bc_d;
  logic [CW_W-1:0]     cw_q, cw_d;
  logic [MB:0]         nfc_q, nfc_d;
  logic [CODE_W-1:0]   prev_q, prev_d;
  logic [1:0]          ph_q, ph_d;
  logic [15:0]         col_q, col_d, row_q, row_d;
  logic [NW-1:0]       n_q, n_d;
  logic                pv_q, pv_d;
  logic [PW-1:0]       pidx_q, pidx_d;
  logic [31:0]         off_q, off_d;
  logic [CODE_W-1:0]   c_q, c_d;
  logic                kw_q, kw_d;
  logic [STACK_AW-1:0] base_q, base_d;
  logic [CODE_W-1:0]   apre_q, apre_d;
  logic [7:0]          first_q, first_d;

  // memory ports
  logic                stk_we, stk_re;
  logic [STACK_AW-1:0] stk_wa, stk_ra;
  logic [7:0]          stk_wd, stk_rd;
  logic                dict_we, dict_re;
  logic [MB-1:0]       dict_wa, dict_ra;
  logic [MB-1:0]       pre_wd, pre_rd;
  logic [7:0]          suf_wd, suf_rd;

  // helpers
  logic [3:0]          em, em_w;
  logic [12:0]         clr13, fe13, pow_cw, nfc13;
  logic [CODE_W-1:0]   code, newc;
  logic [12:0]         code13;
  logic                pend_now;
  logic [16:0]         rowsum;
  logic [32:0]         prod;
  logic [15:0]         col1;
  logic                push_en;
  logic [7:0]          push_val;
  logic [MB:0]         nfc_new;

  glpd_ram #(.WIDTH(MB), .DEPTH(LIMIT), .AW(MB)) u_prefix (
    .clk_i(clk_i), .we_i(dict_we), .waddr_i(dict_wa), .wdata_i(pre_wd),
    .re_i(dict_re), .raddr_i(dict_ra), .rdata_o(pre_rd)
  );

  glpd_ram #(.WIDTH(8), .DEPTH(LIMIT), .AW(MB)) u_suffix (
    .clk_i(clk_i), .we_i(dict_we), .waddr_i(dict_wa), .wdata_i(suf_wd),
    .re_i(dict_re), .raddr_i(dict_ra), .rdata_o(suf_rd)
  );

  glpd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH), .AW(STACK_AW)) u_stack (
    .clk_i(clk_i), .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .re_i(stk_re), .raddr_i(stk_ra), .rdata_o(stk_rd)
  );

  assign em       = eff_min(cfg_i.lzw_size);
  assign em_w     = eff_min(cfg_i.mcs_wdata);
  assign clr13    = 13'd1 << em;
  assign fe13     = clr13 + 13'd2;
  assign pow_cw   = 13'd1 << cw_q;
  assign code     = CODE_W'(bb_q & ((BB_W'(1) << cw_q) - BB_W'(1)));
  assign code13   = {1'b0, code};
  assign newc     = CODE_W'(pre_rd);
  assign pend_now = (sc_q != '0) || (ph_q != PH_DONE && bc_q >= BC_W'(cw_q));
  assign rowsum   = 17'(cfg_i.image_top) + 17'(row_q);
  assign prod     = 33'(cfg_i.screen_width) * 33'(rowsum);
  assign col1     = col_q + 16'd1;
  assign nfc13    = 13'(nfc_q);

  always_comb begin
    st_d = st_q;  sc_d = sc_q;  bb_d = bb_q;  bc_d = bc_q;  cw_d = cw_q;
    nfc_d = nfc_q;  prev_d = prev_q;  ph_d = ph_q;  col_d = col_q;  row_d = row_q;
    n_d = n_q;  pv_d = 1'b0;  pidx_d = pidx_q;  off_d = off_q;  c_d = c_q;
    kw_d = kw_q;  base_d = base_q;  apre_d = apre_q;  first_d = first_q;
    stk_we = 1'b0;  stk_wa = sc_q[STACK_AW-1:0];  stk_wd = 8'd0;
    stk_re = 1'b0;  stk_ra = STACK_AW'(sc_q - SC_W'(1));
    dict_we = 1'b0;  dict_wa = nfc_q[MB-1:0];  pre_wd = apre_q[MB-1:0];
    suf_wd = c_q[7:0];  dict_re = 1'b0;  dict_ra = c_q[MB-1:0];
    res_we_o = 1'b0;  res_wa_o = n_q[PW-1:0];  res_wd_o = '0;
    start_o = 1'b0;  push_en = 1'b0;  push_val = 8'd0;  nfc_new = nfc_q;

    // min code size written while awaiting clear reloads the table state
    if (cfg_i.mcs_we && ph_q == PH_AWAIT_CLEAR) begin
      cw_d  = em_w + 4'd1;
      nfc_d = (MB+1)'((13'd1 << em_w) + 13'd2);
    end

    // pixel read from the stack last cycle lands in the result buffer
    if (pv_q) begin
      res_we_o = 1'b1;
      res_wa_o = pidx_q;
      res_wd_o = '{has_pixel: 1'b1, color_index: stk_rd, pixel_offset: off_q,
                   is_transparent: ({1'b0, stk_rd} == cfg_i.transparent_index),
                   error_code: ERR_NONE};
    end

    case (st_q)
      S_IDLE: begin
        if (in_valid_i && !ob_busy_i) begin
          n_d  = '0;
          st_d = S_EMIT;
          if (!kind_i) begin
            if (pend_now) begin
              res_we_o = 1'b1;
              res_wa_o = '0;
              res_wd_o = '{default: '0, error_code: ERR_PENDING};
              n_d      = NW'(1);
              st_d     = S_FINISH;
            end else if (ph_q != PH_DONE) begin
              bb_d = bb_q | (BB_W'(data_byte_i) << bc_q);
              bc_d = bc_q + BC_W'(8);
            end
          end
        end
      end
      S_EMIT: begin
        if (sc_q != '0 && n_q < NW'(PIXELS_PER_ITEM)) begin
          stk_re = 1'b1;
          sc_d   = sc_q - SC_W'(1);
          pv_d   = 1'b1;
          pidx_d = n_q[PW-1:0];
          off_d  = prod[31:0] + 32'(cfg_i.image_left) + 32'(col_q);
          n_d    = n_q + NW'(1);
          if (col1 >= cfg_i.image_width) begin
            col_d = 16'd0;
            row_d = row_q + 16'd1;
          end else begin
            col_d = col1;
          end
        end else if (sc_q != '0 || ph_q == PH_DONE || bc_q < BC_W'(cw_q)
                     || n_q >= NW'(PIXELS_PER_ITEM)) begin
          st_d = S_FINISH;
        end else begin
          st_d = S_CODE;
        end
      end
      S_CODE: begin
        bb_d = bb_q >> cw_q;
        bc_d = bc_q - BC_W'(cw_q);
        st_d = S_EMIT;
        if (ph_q == PH_AWAIT_CLEAR) begin
          if (code13 != clr13) begin
            res_we_o = 1'b1;
            res_wd_o = '{default: '0, error_code: ERR_FIRST};
            n_d      = n_q + NW'(1);
          end else begin
            cw_d  = em + 4'd1;
            nfc_d = (MB+1)'(fe13);
            ph_d  = PH_AWAIT_FIRST;
          end
        end else if (code13 == clr13) begin
          cw_d  = em + 4'd1;
          nfc_d = (MB+1)'(fe13);
          ph_d  = PH_AWAIT_FIRST;
        end else if (code13 == clr13 + 13'd1) begin
          ph_d = PH_DONE;
        end else if (ph_q == PH_AWAIT_FIRST) begin
          if (code13 > clr13) begin
            res_we_o = 1'b1;
            res_wd_o = '{default: '0, error_code: ERR_RANGE};
            n_d      = n_q + NW'(1);
          end else begin
            push_en  = 1'b1;
            push_val = code[7:0];
            prev_d   = code;
            ph_d     = PH_RUN;
          end
        end else if (code13 <= nfc13) begin
          // known code, or the code being defined right now
          apre_d = prev_q;
          prev_d = code;
          kw_d   = (code13 == nfc13);
          c_d    = (code13 == nfc13) ? prev_q : code;
          if (code13 == nfc13) begin
            push_en  = 1'b1;
            push_val = 8'd0;
            base_d   = sc_q[STACK_AW] ? '0 : sc_q[STACK_AW-1:0];
          end
          if ({1'b0, c_d} >= fe13) begin
            dict_re = 1'b1;
            dict_ra = c_d[MB-1:0];
            st_d    = S_WALK;
          end else begin
            st_d = S_FIN;
          end
        end else begin
          res_we_o = 1'b1;
          res_wd_o = '{default: '0, error_code: ERR_RANGE};
          n_d      = n_q + NW'(1);
        end
      end
      S_WALK: begin
        // one chain link a cycle: push suffix, follow prefix
        push_en  = 1'b1;
        push_val = suf_rd;
        if ({1'b0, newc} >= fe13) begin
          dict_re = 1'b1;
          dict_ra = newc[MB-1:0];
        end else begin
          c_d  = newc;
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        push_en  = 1'b1;
        push_val = c_q[7:0];
        first_d  = c_q[7:0];
        if (nfc_q < (MB+1)'(LIMIT)) begin
          dict_we = 1'b1;
          nfc_new = nfc_q + (MB+1)'(1);
        end
        nfc_d = nfc_new;
        if (13'(nfc_new) == pow_cw && cw_q < CW_W'(MAX_CODE_BITS)) cw_d = cw_q + 4'd1;
        st_d = kw_q ? S_KWFIX : S_EMIT;
      end
      S_KWFIX: begin
        stk_we = 1'b1;
        stk_wa = base_q;
        stk_wd = first_q;
        st_d   = S_EMIT;
      end
      S_FINISH: begin
        start_o = 1'b1;
        st_d    = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase

    // stack push, dropped when full
    if (push_en && !sc_q[STACK_AW]) begin
      stk_we = 1'b1;
      stk_wa = sc_q[STACK_AW-1:0];
      stk_wd = push_val;
      sc_d   = sc_q + SC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      sc_q   <= '0;
      bb_q   <= '0;
      bc_q   <= '0;
      cw_q   <= CW_W'(9);
      nfc_q  <= (MB+1)'(258);
      prev_q <= '0;
      ph_q   <= PH_AWAIT_CLEAR;
      col_q  <= '0;
      row_q  <= '0;
      n_q    <= '0;
      pv_q   <= 1'b0;
      kw_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      sc_q   <= sc_d;
      bb_q   <= bb_d;
      bc_q   <= bc_d;
      cw_q   <= cw_d;
      nfc_q  <= nfc_d;
      prev_q <= prev_d;
      ph_q   <= ph_d;
      col_q  <= col_d;
      row_q  <= row_d;
      n_q    <= n_d;
      pv_q   <= pv_d;
      kw_q   <= kw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    off_q   <= off_d;
    c_q     <= c_d;
    base_q  <= base_d;
    apre_q  <= apre_d;
    first_q <= first_d;
  end

  assign in_ready_o = (st_q == S_IDLE) && !ob_busy_i;
  assign count_o    = n_q;
  assign pend_o     = pend_now;
  assign done_o     = (ph_q == PH_DONE);

endmodule

### tb/sv/glpd_checker.sv
// Checker for the LZW pixel decoder core: watches the register port and both
// item channels, predicts each item's results and compares them in order.
// Depends on glpd_pkg for phase, error and register codes.
module glpd_checker import glpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        has_pixel_i,
  input  logic [7:0]  color_index_i,
  input  logic [31:0] pixel_offset_i,
  input  logic        is_transparent_i,
  input  logic        more_pending_i,
  input  logic        frame_done_i,
  input  logic [1:0]  error_code_i,
  input  logic        last_i,
  output int unsigned mismatch_o,
  output int unsigned waiting_o,
  output int unsigned pixels_o
);

  localparam int unsigned MAX_PIX  = 64;
  localparam int unsigned DICT_LEN = 4096;

  typedef struct packed {
    logic        has_pixel;
    logic [7:0]  color_index;
    logic [31:0] pixel_offset;
    logic        is_transparent;
    logic        more_pending;
    logic        frame_done;
    logic [1:0]  error_code;
    logic        last;
  } pix_res_t;

  pix_res_t pix_due_q[$];
  pix_res_t item_q[$];

  // shadow registers
  logic [3:0]  r_min;
  logic [15:0] r_left, r_top, r_width, r_screen;
  logic [8:0]  r_transp;

  // shadow decoder state
  logic [11:0] pre_mem[DICT_LEN];
  logic [7:0]  suf_mem[DICT_LEN];
  logic [7:0]  sym_stk[DICT_LEN];
  int unsigned sym_n, bit_acc, bit_n, width, free_code, last_code, col, row;
  logic [1:0]  phase;

  function automatic int unsigned clamp_min(logic [3:0] m);
    if (m < 2) return 2;
    if (m > 8) return 8;
    return m;
  endfunction

  function void restart_dict();
    width     = clamp_min(r_min) + 1;
    free_code = (1 << clamp_min(r_min)) + 2;
  endfunction

  function void push_sym(int unsigned v);
    if (sym_n < DICT_LEN) begin
      sym_stk[sym_n] = v[7:0];
      sym_n++;
    end
  endfunction

  // push the string of code c, last symbol first; give back its first symbol
  function int unsigned unwind(int unsigned c);
    int unsigned first_entry, steps;
    first_entry = (1 << clamp_min(r_min)) + 2;
    steps = 0;
    c = c & (DICT_LEN - 1);
    while (c >= first_entry && steps < DICT_LEN) begin
      push_sym(suf_mem[c]);
      c = pre_mem[c];
      steps++;
    end
    push_sym(c);
    return c & 8'hFF;
  endfunction

  function void grow_dict(int unsigned pre, int unsigned suf);
    if (free_code < DICT_LEN) begin
      pre_mem[free_code] = pre[11:0];
      suf_mem[free_code] = suf[7:0];
      free_code++;
    end
    if (free_code == (1 << width) && width < 12) width++;
  endfunction

  function void add_res(logic hp, logic [7:0] ci, logic [31:0] off, logic tr,
                        logic [1:0] err);
    pix_res_t r;
    r = '0;
    r.has_pixel = hp;
    r.color_index = ci;
    r.pixel_offset = off;
    r.is_transparent = tr;
    r.error_code = err;
    item_q.push_back(r);
  endfunction

  function void emit_pixel();
    logic [7:0]  ci;
    logic [31:0] off;
    sym_n--;
    ci  = sym_stk[sym_n % DICT_LEN];
    off = 32'(r_screen) * (32'(r_top) + 32'(row)) + 32'(r_left) + 32'(col);
    add_res(1'b1, ci, off, {1'b0, ci} == r_transp, ERR_NONE);
    col = (col + 1) & 16'hFFFF;
    if (col >= r_width) begin
      col = 0;
      row = (row + 1) & 16'hFFFF;
    end
  endfunction

  function logic [1:0] decode_code(int unsigned code);
    int unsigned clr, first, base;
    clr = 1 << clamp_min(r_min);
    if (phase == PH_AWAIT_CLEAR) begin
      if (code != clr) return ERR_FIRST;
      restart_dict();
      phase = PH_AWAIT_FIRST;
      return ERR_NONE;
    end
    if (code == clr) begin
      restart_dict();
      phase = PH_AWAIT_FIRST;
      return ERR_NONE;
    end
    if (code == clr + 1) begin
      phase = PH_DONE;
      return ERR_NONE;
    end
    if (phase == PH_AWAIT_FIRST) begin
      if (code > clr) return ERR_RANGE;
      push_sym(code);
      last_code = code;
      phase = PH_RUN;
      return ERR_NONE;
    end
    if (code < free_code) begin
      first = unwind(code);
      grow_dict(last_code, first);
    end else if (code == free_code) begin
      // KwKwK: the string of the previous code plus its own first symbol
      base = sym_n;
      push_sym(0);
      first = unwind(last_code);
      sym_stk[base < DICT_LEN ? base : 0] = first[7:0];
      grow_dict(last_code, first);
    end else begin
      return ERR_RANGE;
    end
    last_code = code & 12'hFFF;
    return ERR_NONE;
  endfunction

  function logic work_left();
    return sym_n > 0 || (phase != PH_DONE && bit_n >= width);
  endfunction

  function void predict_item(logic k, logic [7:0] b);
    logic        dropped;
    logic        pend, done;
    logic [1:0]  err;
    int unsigned code;
    item_q.delete();
    dropped = 1'b0;
    if (!k) begin
      if (work_left()) begin
        add_res(1'b0, 8'd0, 32'd0, 1'b0, ERR_PENDING);
        dropped = 1'b1;
      end else if (phase != PH_DONE) begin
        bit_acc = bit_acc | (int'(b) << bit_n);
        bit_n += 8;
      end
    end
    if (!dropped) begin
      while (1) begin
        while (sym_n > 0 && item_q.size() < MAX_PIX) emit_pixel();
        if (sym_n > 0 || phase == PH_DONE) break;
        if (bit_n < width || item_q.size() >= MAX_PIX) break;
        code    = bit_acc & ((1 << width) - 1);
        bit_acc = (bit_acc >> width) & 24'hFFFFFF;
        bit_n  -= width;
        err = decode_code(code);
        if (err != ERR_NONE) add_res(1'b0, 8'd0, 32'd0, 1'b0, err);
      end
    end
    if (item_q.size() == 0) add_res(1'b0, 8'd0, 32'd0, 1'b0, ERR_NONE);
    pend = work_left();
    done = phase == PH_DONE;
    foreach (item_q[i]) begin
      item_q[i].more_pending = pend;
      item_q[i].frame_done = done;
      item_q[i].last = (i == item_q.size() - 1);
      pix_due_q.push_back(item_q[i]);
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_MIN_CODE: begin
        r_min = data[3:0];
        if (phase == PH_AWAIT_CLEAR) restart_dict();
      end
      REG_LEFT:   r_left = data[15:0];
      REG_TOP:    r_top = data[15:0];
      REG_WIDTH:  r_width = data[15:0];
      REG_SCREEN: r_screen = data[15:0];
      REG_TRANSP: r_transp = data[8:0];
      default: ;
    endcase
  endfunction

  initial begin
    r_min = 4'd8; r_left = '0; r_top = '0; r_width = 16'd1; r_screen = 16'd1;
    r_transp = 9'd256;
    foreach (pre_mem[i]) begin
      pre_mem[i] = '0;
      suf_mem[i] = '0;
      sym_stk[i] = '0;
    end
    sym_n = 0; bit_acc = 0; bit_n = 0; last_code = 0; col = 0; row = 0;
    phase = PH_AWAIT_CLEAR;
    restart_dict();
    mismatch_o = 0;
    waiting_o = 0;
    pixels_o = 0;
  end

  // sample both channels and the register port at each edge
  always @(posedge clk_i) begin
    pix_res_t got, want;
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i && pready_i)
        write_reg(3'(paddr_i >> 2), pwdata_i);
      if (in_valid_i && !in_stall_i) predict_item(kind_i, data_byte_i);
      if (out_valid_i && !out_stall_i) begin
        got = {has_pixel_i, color_index_i, pixel_offset_i, is_transparent_i,
               more_pending_i, frame_done_i, error_code_i, last_i};
        if (has_pixel_i) pixels_o++;
        if (pix_due_q.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= 10) $display("unexpected result: %p", got);
        end else begin
          want = pix_due_q.pop_front();
          if (got !== want) begin
            mismatch_o++;
            if (mismatch_o <= 10)
              $display("mismatch at %0t\n  expected %p\n  actual   %p", $realtime,
                       want, got);
          end
        end
      end
      waiting_o = pix_due_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// Top of the LZW pixel decoder testbench: clock, reset, register writes, an
// encoder that builds code streams with clears, KwKwK and bad codes, random idling and the verdict.
// Depends on glpd_pkg, glpd_checker and the gif_lzw_pixel_decoder_core RTL.
module testbench import glpd_pkg::*;;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_stall_o, kind_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o, out_stall_i;
  logic        has_pixel_o, is_transparent_o, more_pending_o, frame_done_o, last_o;
  logic [7:0]  color_index_o;
  logic [31:0] pixel_offset_o;
  logic [1:0]  error_code_o;

  int unsigned mismatches, waiting, pixels;
  int unsigned items_sent, items_done, settings_used;
  logic        pend_flag, hold_on, calm;

  // encoder side: mirrors the decoder's width and dictionary size
  logic [3:0]  enc_raw;
  int unsigned enc_w, enc_nf, enc_phase, acc, acc_n;
  logic [7:0]  stream_q[$];

  gif_lzw_pixel_decoder_core u_top (.*);

  glpd_checker u_chk (
    .clk_i, .rst_ni, .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
    .paddr_i(paddr), .pwdata_i(pwdata), .pready_i(pready),
    .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .data_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .has_pixel_i(has_pixel_o),
    .color_index_i(color_index_o), .pixel_offset_i(pixel_offset_o),
    .is_transparent_i(is_transparent_o), .more_pending_i(more_pending_o),
    .frame_done_i(frame_done_o), .error_code_i(error_code_o), .last_i(last_o),
    .mismatch_o(mismatches), .waiting_o(waiting), .pixels_o(pixels)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned clamp_size(logic [3:0] m);
    if (m < 2) return 2;
    if (m > 8) return 8;
    return m;
  endfunction

  // pack one code LSB first at the current width, then track the decoder
  function void pack_code(int unsigned code);
    int unsigned clr;
    acc = acc | (code << acc_n);
    acc_n += enc_w;
    while (acc_n >= 8) begin
      stream_q.push_back(acc[7:0]);
      acc = acc >> 8;
      acc_n -= 8;
    end
    clr = 1 << clamp_size(enc_raw);
    if (enc_phase == PH_AWAIT_CLEAR) begin
      if (code == clr) begin
        enc_w = clamp_size(enc_raw) + 1; enc_nf = clr + 2; enc_phase = PH_AWAIT_FIRST;
      end
    end else if (code == clr) begin
      enc_w = clamp_size(enc_raw) + 1; enc_nf = clr + 2; enc_phase = PH_AWAIT_FIRST;
    end else if (code == clr + 1) begin
      enc_phase = PH_DONE;
    end else if (enc_phase == PH_AWAIT_FIRST) begin
      if (code < clr) enc_phase = PH_RUN;
    end else if (code <= enc_nf) begin
      if (enc_nf < 4096) enc_nf++;
      if (enc_nf == (1 << enc_w) && enc_w < 12) enc_w++;
    end
  endfunction

  // mostly valid codes, some clears, KwKwK cases and codes out of range
  function int unsigned pick_code();
    int unsigned clr, top_code, r;
    clr = 1 << clamp_size(enc_raw);
    top_code = (1 << enc_w) - 1;
    r = $urandom_range(0, 99);
    if (enc_phase == PH_AWAIT_FIRST) begin
      if (r < 10 && clr + 2 <= top_code) return $urandom_range(clr + 2, top_code);
      return $urandom_range(0, clr - 1);
    end
    if (r < 6 && enc_nf + 1 <= top_code) return $urandom_range(enc_nf + 1, top_code);
    if (r < 10) return clr;
    if (r < 25 && enc_nf <= top_code) return enc_nf;
    if (r < 55 || enc_nf <= clr + 2) return $urandom_range(0, clr - 1);
    return $urandom_range(clr + 2, enc_nf - 1);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 2; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_MIN_CODE) begin
      enc_raw = data[3:0];
      settings_used++;
      if (enc_phase == PH_AWAIT_CLEAR) begin
        enc_w = clamp_size(enc_raw) + 1;
        enc_nf = (1 << clamp_size(enc_raw)) + 2;
      end
    end
  endtask

  task automatic send_item(logic k, logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i <= k; data_byte_i <= b; in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // wait for the previous item's results; under a long hold keep offering
  task automatic settle();
    while (items_done != items_sent) begin
      if (hold_on) send_item(1'b1, 8'($urandom));
      else begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  task automatic send_stream_byte(logic [7:0] b);
    while (1) begin
      settle();
      if (pend_flag) begin
        // a stray byte while pixels wait is rejected and must not be counted
        if ($urandom_range(0, 9) == 0) send_item(1'b0, 8'($urandom));
        else send_item(1'b1, 8'($urandom));
      end else if ($urandom_range(0, 19) == 0) begin
        send_item(1'b1, 8'($urandom));
      end else begin
        send_item(1'b0, b);
        break;
      end
    end
  endtask

  task automatic flush_stream();
    while (stream_q.size() > 0) send_stream_byte(stream_q.pop_front());
    settle();
    while (pend_flag) begin
      send_item(1'b1, 8'($urandom));
      settle();
    end
    in_valid_i <= 1'b0;
    while (waiting != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // new code size, limited to what the current width can still carry
  task automatic random_phase(logic [3:0] want_raw, int unsigned n_codes);
    logic [3:0] raw;
    raw = want_raw;
    if (clamp_size(raw) > enc_w - 1) raw = 4'(enc_w - 1);
    write_reg(REG_MIN_CODE, {$urandom} & 32'hFFFF_FFF0 | raw);
    write_reg(REG_LEFT, $urandom);
    write_reg(REG_TOP, $urandom);
    write_reg(REG_WIDTH, $urandom_range(1, 12) | ($urandom_range(0, 3) == 0 ? $urandom : 0));
    write_reg(REG_SCREEN, $urandom);
    write_reg(REG_TRANSP, $urandom_range(0, 3) == 0 ? 256 + $urandom_range(0, 255)
                                                      : $urandom_range(0, 7));
    pack_code(1 << clamp_size(enc_raw));
    repeat (n_codes) pack_code(pick_code());
    flush_stream();
  endtask

  // receiver: random stall per result, plus one long hold
  initial begin
    int unsigned wait_left;
    wait_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        wait_left = calm ? 0 : $urandom_range(0, 9);
        if (last_o) begin
          pend_flag = more_pending_o;
          items_done++;
        end
      end
      if (hold_on) out_stall_i <= 1'b1;
      else if (wait_left > 0) begin
        out_stall_i <= 1'b1;
        wait_left--;
      end else out_stall_i <= 1'b0;
    end
  end

  initial begin
    hold_on = 1'b0;
    wait (items_sent >= 60);
    @(posedge clk_i);
    hold_on = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_on = 1'b0;
  end

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid_i <= 1'b0; kind_i <= 1'b0; data_byte_i <= '0;
    items_sent = 0; items_done = 0; settings_used = 0;
    pend_flag = 1'b0; calm = 1'b0;
    enc_raw = 4'd8; enc_w = 9; enc_nf = 258; enc_phase = PH_AWAIT_CLEAR;
    acc = 0; acc_n = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme registers, size 15 acting as 8, all error cases
    write_reg(REG_MIN_CODE, 32'd15);
    write_reg(REG_LEFT, 32'hFFFF);
    write_reg(REG_TOP, 32'hFFFF);
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_SCREEN, 32'hFFFF);
    write_reg(REG_TRANSP, 32'd255);
    send_item(1'b1, 8'hFF);          // resume with nothing pending
    pack_code(5);                    // first code not clear
    pack_code(256);
    pack_code(256);                  // clear right after clear
    pack_code(300);                  // beyond next free before first literal
    pack_code(0);
    pack_code(258);                  // KwKwK
    pack_code(255);
    pack_code(259);
    pack_code(400);                  // beyond next free
    pack_code(261);                  // KwKwK again
    pack_code(128);
    pack_code(1);
    flush_stream();

    // random phases through several code sizes, 0 acting as 2
    random_phase(4'd4, 50);
    calm = 1'b1;
    random_phase(4'd0, 60);
    calm = 1'b0;
    random_phase(4'd6, 60);
    random_phase(4'd3, 60);
    random_phase(4'd8, 40);

    // end code, padding, then bytes after the end
    pack_code((1 << clamp_size(enc_raw)) + 1);
    if (acc_n > 0) begin
      stream_q.push_back(acc[7:0] | (8'($urandom) << acc_n));
      acc_n = 0;
    end
    stream_q.push_back(8'($urandom));
    stream_q.push_back(8'($urandom));
    flush_stream();

    in_valid_i <= 1'b0;
    while (waiting != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items (bytes and resumes), checked %0d pixels,", items_sent, pixels);
    $display("over %0d code-size settings with errors, KwKwK and a long output hold.",
             settings_used);
    if (mismatches == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
